FILE: src/midi_cc_rate_limiter_core_defines.svh
// ----------------------------------------------------------------------------
// MIDI CC rate limiter assertion macros
// Shared concurrent assertion forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef MIDI_CC_RATE_LIMITER_CORE_DEFINES_SVH
`define MIDI_CC_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define MCCRL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define MCCRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mccrl_pkg.sv
// ----------------------------------------------------------------------------
// MIDI CC rate limiter package
// Controller states, command and status bundles, and the controller table.
// ----------------------------------------------------------------------------
package mccrl_pkg;

  localparam logic [7:0]  CC_TYPE          = 8'hB0;
  localparam logic [15:0] INTERVAL_DEFAULT = 16'd40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSG,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic msg_go;
    logic step_go;
    logic final_go;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cand;
    logic held_valid;
    logic scan_end;
  } status_t;

  function automatic logic [6:0] cc_code(input logic [2:0] idx);
    logic [6:0] code;
    unique case (idx)
      3'd0:    code = 7'd64;
      3'd1:    code = 7'd65;
      3'd2:    code = 7'd66;
      3'd3:    code = 7'd67;
      3'd4:    code = 7'd91;
      3'd5:    code = 7'd93;
      3'd6:    code = 7'd7;
      3'd7:    code = 7'd11;
      default: code = 7'd0;
    endcase
    return code;
  endfunction

endpackage

FILE: src/midi_cc_rate_limiter_core.sv
// Message item: accepted in idle, its single result is registered in the message state once the output is free;
// a new message is taken only after the previous result has been registered.
// Flush tick: one table entry per cycle while the output is free, walking all CHANNELS*CONTROLLERS entries;
// each flushed result leaves one candidate later through a one-entry lookahead register.
// Synchronous active-high reset restores interval 40 and clears every entry to zero at once.
// ----------------------------------------------------------------------------
// MIDI CC rate limiter core
// Passes or holds back control changes per entry and flushes pending values on a tick.
// ----------------------------------------------------------------------------
module midi_cc_rate_limiter_core #(
  parameter int CHANNELS    = 3,
  parameter int CONTROLLERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] now_ms,
  input  logic [7:0]  message_type,
  input  logic [4:0]  channel,
  input  logic [6:0]  controller_number,
  input  logic [6:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        forward,
  output logic        generated,
  output logic [4:0]  out_channel,
  output logic [6:0]  out_controller,
  output logic [6:0]  out_value,
  output logic        last
);

  mccrl_pkg::cmd_t    cmd;
  mccrl_pkg::status_t st;

  mccrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (operation),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mccrl_dp #(
    .CHANNELS    (CHANNELS),
    .CONTROLLERS (CONTROLLERS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .operation         (operation),
    .now_ms            (now_ms),
    .message_type      (message_type),
    .channel           (channel),
    .controller_number (controller_number),
    .value             (value),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .forward           (forward),
    .generated         (generated),
    .out_channel       (out_channel),
    .out_controller    (out_controller),
    .out_value         (out_value),
    .last              (last)
  );

endmodule

FILE: src/mccrl_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI CC rate limiter controller
// Sequences message lookups and table flush walks, and issues datapath commands.
// ----------------------------------------------------------------------------
`include "midi_cc_rate_limiter_core_defines.svh"

module mccrl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_stall,
  input  mccrl_pkg::status_t st,
  output mccrl_pkg::cmd_t    cmd
);

  mccrl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mccrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mccrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = in_op ? mccrl_pkg::ST_SCAN : mccrl_pkg::ST_MSG;
        end
      end
      mccrl_pkg::ST_MSG: begin
        if (st.out_free) begin
          state_next = mccrl_pkg::ST_IDLE;
        end
      end
      mccrl_pkg::ST_SCAN: begin
        if (cmd.step_go && st.scan_end) begin
          state_next = mccrl_pkg::ST_FINAL;
        end
      end
      mccrl_pkg::ST_FINAL: begin
        if (!st.held_valid || st.out_free) begin
          state_next = mccrl_pkg::ST_IDLE;
        end
      end
      default: state_next = mccrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      mccrl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      mccrl_pkg::ST_MSG: begin
        cmd.msg_go = st.out_free;
      end
      mccrl_pkg::ST_SCAN: begin
        cmd.step_go = !st.cand || !st.held_valid || st.out_free;
      end
      mccrl_pkg::ST_FINAL: begin
        cmd.final_go = !st.held_valid || st.out_free;
      end
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  `MCCRL_ASSERT_NEXT(a_load_leaves_idle, clk, rst, cmd.load, state != mccrl_pkg::ST_IDLE, "transfer accepted but controller stayed idle")
  `MCCRL_ASSERT_NEXT(a_walk_end_final, clk, rst, cmd.step_go && st.scan_end, state == mccrl_pkg::ST_FINAL, "table walk ended without the final step")
  `MCCRL_ASSERT_NEXT(a_final_to_idle, clk, rst, cmd.final_go, state == mccrl_pkg::ST_IDLE, "final step did not return to idle")

endmodule

FILE: src/mccrl_dp.sv
// ----------------------------------------------------------------------------
// MIDI CC rate limiter datapath
// Holds the input item, the per-entry table, the flush lookahead and the output stage.
// ----------------------------------------------------------------------------
`include "midi_cc_rate_limiter_core_defines.svh"

module mccrl_dp #(
  parameter int CHANNELS    = 3,
  parameter int CONTROLLERS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               operation,
  input  logic [31:0]        now_ms,
  input  logic [7:0]         message_type,
  input  logic [4:0]         channel,
  input  logic [6:0]         controller_number,
  input  logic [6:0]         value,
  input  mccrl_pkg::cmd_t    cmd,
  output mccrl_pkg::status_t st,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               forward,
  output logic               generated,
  output logic [4:0]         out_channel,
  output logic [6:0]         out_controller,
  output logic [6:0]         out_value,
  output logic               last
);

  localparam int ENTRIES = CHANNELS * CONTROLLERS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CTL_W   = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;

  logic [15:0] interval;
  logic        op_r;
  logic [31:0] now_r;
  logic [7:0]  type_r;
  logic [4:0]  ch_r;
  logic [6:0]  ctl_r;
  logic [6:0]  val_r;

  logic [31:0]      sent_time [ENTRIES];
  logic [6:0]       sent_val  [ENTRIES];
  logic [6:0]       pend_val  [ENTRIES];
  logic [ENTRIES-1:0] ent_valid;

  logic [IDX_W-1:0] scan_idx;
  logic [CH_W-1:0]  scan_ch;
  logic [CTL_W-1:0] scan_ctl;

  logic       held_valid;
  logic [4:0] held_ch;
  logic [6:0] held_ctl;
  logic [6:0] held_val;

  logic             match;
  logic [CTL_W-1:0] match_i;
  logic             tracked;
  logic [IDX_W-1:0] msg_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_time;
  logic [6:0]       rd_sent;
  logic [6:0]       rd_pend;
  logic [31:0]      elapsed_ms;
  logic             elapsed;
  logic             cand;
  logic             wr_en;
  logic [31:0]      wr_time;
  logic [6:0]       wr_sent;
  logic [6:0]       wr_pend;
  logic             out_free;
  logic             push;
  logic             push_gen;
  logic             push_fwd;
  logic             push_last;
  logic [4:0]       push_ch;
  logic [6:0]       push_ctl;
  logic [6:0]       push_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= mccrl_pkg::INTERVAL_DEFAULT;
    end else if (cfg_write) begin
      interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= operation;
      now_r  <= now_ms;
      type_r <= message_type;
      ch_r   <= channel;
      ctl_r  <= controller_number;
      val_r  <= value;
    end
  end

  always_comb begin
    match   = 1'b0;
    match_i = '0;
    for (int k = 0; k < CONTROLLERS; k++) begin
      if (!match && ctl_r == mccrl_pkg::cc_code(3'(k))) begin
        match   = 1'b1;
        match_i = CTL_W'(k);
      end
    end
  end

  assign tracked = (type_r == mccrl_pkg::CC_TYPE) && (ch_r >= 5'd1)
                   && (ch_r <= 5'(CHANNELS)) && match;
  assign msg_idx = tracked ? IDX_W'((int'(ch_r) - 1) * CONTROLLERS + int'(match_i)) : '0;
  assign rd_idx  = op_r ? scan_idx : msg_idx;

  assign rd_time = ent_valid[rd_idx] ? sent_time[rd_idx] : '0;
  assign rd_sent = ent_valid[rd_idx] ? sent_val[rd_idx]  : '0;
  assign rd_pend = ent_valid[rd_idx] ? pend_val[rd_idx]  : '0;

  assign elapsed_ms = now_r - rd_time;
  assign elapsed    = elapsed_ms >= {16'd0, interval};
  assign cand       = (rd_pend != rd_sent) && elapsed;

  always_comb begin
    wr_en   = 1'b0;
    wr_time = rd_time;
    wr_sent = rd_sent;
    wr_pend = rd_pend;
    if (cmd.msg_go && tracked) begin
      wr_en   = 1'b1;
      wr_pend = val_r;
      if (elapsed) begin
        wr_sent = val_r;
        wr_time = now_r;
      end
    end else if (cmd.step_go && cand) begin
      wr_en   = 1'b1;
      wr_sent = rd_pend;
      wr_time = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[rd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sent_time[rd_idx] <= wr_time;
      sent_val[rd_idx]  <= wr_sent;
      pend_val[rd_idx]  <= wr_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      scan_ch  <= '0;
      scan_ctl <= '0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      scan_ch  <= '0;
      scan_ctl <= '0;
    end else if (cmd.step_go) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (scan_ctl == CTL_W'(CONTROLLERS - 1)) begin
        scan_ctl <= '0;
        scan_ch  <= scan_ch + CH_W'(1);
      end else begin
        scan_ctl <= scan_ctl + CTL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.load || cmd.final_go) begin
      held_valid <= 1'b0;
    end else if (cmd.step_go && cand) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_go && cand) begin
      held_ch  <= 5'(scan_ch) + 5'd1;
      held_ctl <= mccrl_pkg::cc_code(3'(scan_ctl));
      held_val <= rd_pend;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    push      = 1'b0;
    push_fwd  = 1'b0;
    push_gen  = 1'b0;
    push_last = 1'b0;
    push_ch   = '0;
    push_ctl  = '0;
    push_val  = '0;
    if (cmd.msg_go) begin
      push      = 1'b1;
      push_fwd  = !tracked || elapsed;
      push_last = 1'b1;
    end else if ((cmd.step_go && cand && held_valid) || (cmd.final_go && held_valid)) begin
      push      = 1'b1;
      push_gen  = 1'b1;
      push_last = cmd.final_go;
      push_ch   = held_ch;
      push_ctl  = held_ctl;
      push_val  = held_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      forward        <= push_fwd;
      generated      <= push_gen;
      out_channel    <= push_ch;
      out_controller <= push_ctl;
      out_value      <= push_val;
      last           <= push_last;
    end
  end

  assign st.out_free   = out_free;
  assign st.cand       = cand;
  assign st.held_valid = held_valid;
  assign st.scan_end   = scan_idx == IDX_W'(ENTRIES - 1);

  `MCCRL_ASSERT_IMPL(a_no_overwrite, clk, rst, push, out_free, "result over stalled transfer")
  `MCCRL_ASSERT_NEXT(a_final_clears_held, clk, rst, cmd.final_go, !held_valid, "held result kept")
  `MCCRL_ASSERT_IMPL(a_flush_not_forward, clk, rst, out_valid && generated, !forward, "flush forwarded")

endmodule

FILE: tb/midi_cc_rate_limiter_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI CC rate limiter checker
// Watches both channels of the core and keeps its own copy of the throttle
// table and interval. For every input transfer it predicts the results and
// compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
package mccrl_tb_pkg;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [7:0] NOTE_ON_TYPE = 8'h90;

  localparam int TRACKED_CHANNELS    = 3;
  localparam int TRACKED_CONTROLLERS = 8;

  localparam logic [7:0][6:0] TRACKED_CC = {
    7'd11, 7'd7, 7'd93, 7'd91, 7'd67, 7'd66, 7'd65, 7'd64
  };

endpackage

module midi_cc_rate_limiter_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [31:0] now_ms,
  input  logic [7:0]  message_type,
  input  logic [4:0]  channel,
  input  logic [6:0]  controller_number,
  input  logic [6:0]  value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        forward,
  input  logic        generated,
  input  logic [4:0]  out_channel,
  input  logic [6:0]  out_controller,
  input  logic [6:0]  out_value,
  input  logic        last,
  output int          fail_count,
  output int          waiting_count
);

  localparam int ENTRIES =
    mccrl_tb_pkg::TRACKED_CHANNELS * mccrl_tb_pkg::TRACKED_CONTROLLERS;

  typedef struct packed {
    logic       forward;
    logic       generated;
    logic [4:0] chan;
    logic [6:0] ctl;
    logic [6:0] val;
    logic       last;
  } cc_result_t;

  cc_result_t  expected_q[$];
  cc_result_t  got;
  logic [31:0] sent_time [0:ENTRIES-1];
  logic [6:0]  sent_val [0:ENTRIES-1];
  logic [6:0]  pend_val [0:ENTRIES-1];
  logic [15:0] interval_ms;
  int          fails = 0;

  initial begin
    fail_count    = 0;
    waiting_count = 0;
  end

  task automatic flag_mismatch(input string what, input cc_result_t exp_r,
                               input cc_result_t got_r);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected fwd=%0b gen=%0b ch=%0d ctl=%0d val=%0d last=%0b",
               $realtime, what, exp_r.forward, exp_r.generated, exp_r.chan, exp_r.ctl,
               exp_r.val, exp_r.last);
      $display("%0t: %s: actual   fwd=%0b gen=%0b ch=%0d ctl=%0d val=%0d last=%0b",
               $realtime, what, got_r.forward, got_r.generated, got_r.chan, got_r.ctl,
               got_r.val, got_r.last);
    end
  endtask

  task automatic predict_transfer();
    int          e;
    int          idx;
    int          c;
    int          i;
    logic [31:0] age;
    cc_result_t  r;
    cc_result_t  held;
    bit          have_held;
    r = '0;
    have_held = 1'b0;
    if (operation == mccrl_tb_pkg::OP_MESSAGE) begin
      r.forward = 1'b1;
      r.last = 1'b1;
      if (message_type == mccrl_pkg::CC_TYPE && channel >= 1
          && channel <= mccrl_tb_pkg::TRACKED_CHANNELS) begin
        idx = -1;
        for (i = 0; i < mccrl_tb_pkg::TRACKED_CONTROLLERS; i++) begin
          if (idx < 0 && controller_number == mccrl_tb_pkg::TRACKED_CC[i]) idx = i;
        end
        if (idx >= 0) begin
          e = (int'(channel) - 1) * mccrl_tb_pkg::TRACKED_CONTROLLERS + idx;
          pend_val[e] = value;
          age = now_ms - sent_time[e];
          if (age < {16'd0, interval_ms}) begin
            r.forward = 1'b0;
          end else begin
            sent_val[e] = value;
            sent_time[e] = now_ms;
          end
        end
      end
      expected_q.push_back(r);
    end else begin
      for (c = 0; c < mccrl_tb_pkg::TRACKED_CHANNELS; c++) begin
        for (i = 0; i < mccrl_tb_pkg::TRACKED_CONTROLLERS; i++) begin
          e = c * mccrl_tb_pkg::TRACKED_CONTROLLERS + i;
          age = now_ms - sent_time[e];
          if (pend_val[e] != sent_val[e] && age >= {16'd0, interval_ms}) begin
            sent_val[e] = pend_val[e];
            sent_time[e] = now_ms;
            if (have_held) expected_q.push_back(held);
            held = '0;
            held.generated = 1'b1;
            held.chan = 5'(c + 1);
            held.ctl = mccrl_tb_pkg::TRACKED_CC[i];
            held.val = pend_val[e];
            have_held = 1'b1;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        expected_q.push_back(held);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) begin
        sent_time[k] = '0;
        sent_val[k] = '0;
        pend_val[k] = '0;
      end
      interval_ms = mccrl_pkg::INTERVAL_DEFAULT;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {forward, generated, out_channel, out_controller, out_value, last};
        if (expected_q.size() == 0) begin
          flag_mismatch("transfer with no result expected", '0, got);
        end else if (expected_q[0] !== got) begin
          flag_mismatch("result mismatch", expected_q[0], got);
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      if (cfg_write) interval_ms = cfg_data;
      if (in_valid && !in_stall) predict_transfer();
    end
    fail_count <= fails;
    waiting_count <= expected_q.size();
  end

endmodule

FILE: tb/midi_cc_rate_limiter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI CC rate limiter testbench
// Drives directed and random messages and flush ticks through the core under
// several interval settings, with random gaps and output stalls, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module midi_cc_rate_limiter_core_tb;

  localparam int RANDOM_ITEMS  = 30;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 3000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [31:0] now_ms;
  logic [7:0]  message_type;
  logic [4:0]  channel;
  logic [6:0]  controller_number;
  logic [6:0]  value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        forward;
  logic        generated;
  logic [4:0]  out_channel;
  logic [6:0]  out_controller;
  logic [6:0]  out_value;
  logic        last;

  int          fail_count;
  int          waiting_count;
  logic        calm;
  logic        hold_req;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] ms_counter;

  midi_cc_rate_limiter_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .now_ms            (now_ms),
    .message_type      (message_type),
    .channel           (channel),
    .controller_number (controller_number),
    .value             (value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .forward           (forward),
    .generated         (generated),
    .out_channel       (out_channel),
    .out_controller    (out_controller),
    .out_value         (out_value),
    .last              (last)
  );

  midi_cc_rate_limiter_core_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .now_ms            (now_ms),
    .message_type      (message_type),
    .channel           (channel),
    .controller_number (controller_number),
    .value             (value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .forward           (forward),
    .generated         (generated),
    .out_channel       (out_channel),
    .out_controller    (out_controller),
    .out_value         (out_value),
    .last              (last),
    .fail_count        (fail_count),
    .waiting_count     (waiting_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver holds off once for a long stretch so that the core fills up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] t, input logic [7:0] mtype,
                           input logic [4:0] ch, input logic [6:0] ctl,
                           input logic [6:0] val);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    now_ms <= t;
    message_type <= mtype;
    channel <= ch;
    controller_number <= ctl;
    value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int step_max);
    int pick;
    ms_counter = ms_counter + $urandom_range(0, step_max);
    if ($urandom_range(0, 99) < 3) ms_counter = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_item(mccrl_tb_pkg::OP_MESSAGE, ms_counter, mccrl_pkg::CC_TYPE,
                5'($urandom_range(1, mccrl_tb_pkg::TRACKED_CHANNELS)),
                mccrl_tb_pkg::TRACKED_CC[$urandom_range(0,
                  mccrl_tb_pkg::TRACKED_CONTROLLERS - 1)],
                7'($urandom_range(0, 127)));
    end else if (pick < 85) begin
      send_item(mccrl_tb_pkg::OP_TICK, ms_counter, 8'($urandom_range(0, 255)),
                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
    end else if (pick < 92) begin
      send_item(mccrl_tb_pkg::OP_MESSAGE, ms_counter, mccrl_pkg::CC_TYPE,
                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
    end else begin
      send_item(mccrl_tb_pkg::OP_MESSAGE, ms_counter, 8'($urandom_range(0, 255)),
                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] interval, input int step_max,
                           input logic no_idling, input logic squeeze);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= interval;
    @(posedge clk);
    cfg_write <= 1'b0;
    calm <= no_idling;
    hold_req <= squeeze;
    repeat (RANDOM_ITEMS) send_random(step_max);
    calm <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = mccrl_tb_pkg::OP_MESSAGE;
    now_ms = '0;
    message_type = '0;
    channel = '0;
    controller_number = '0;
    value = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd0, mccrl_pkg::CC_TYPE, 5'd1, 7'd64, 7'd127);
    send_item(mccrl_tb_pkg::OP_TICK, 32'd39, 8'd0, 5'd0, 7'd0, 7'd0);
    send_item(mccrl_tb_pkg::OP_TICK, 32'd40, 8'd0, 5'd0, 7'd0, 7'd0);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd100, mccrl_pkg::CC_TYPE, 5'd3, 7'd11, 7'd0);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd101, mccrl_pkg::CC_TYPE, 5'd3, 7'd11, 7'd5);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd101, mccrl_pkg::CC_TYPE, 5'd2, 7'd7, 7'd127);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd101, mccrl_pkg::CC_TYPE, 5'd2, 7'd93, 7'd1);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd102, mccrl_tb_pkg::NOTE_ON_TYPE, 5'd1, 7'd64,
              7'd33);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd102, 8'hFF, 5'd1, 7'd64, 7'd127);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd102, 8'h00, 5'd31, 7'd127, 7'd0);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd103, mccrl_pkg::CC_TYPE, 5'd0, 7'd64, 7'd9);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd103, mccrl_pkg::CC_TYPE, 5'd4, 7'd65, 7'd9);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd103, mccrl_pkg::CC_TYPE, 5'd16, 7'd66, 7'd9);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd103, mccrl_pkg::CC_TYPE, 5'd31, 7'd67, 7'd9);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd104, mccrl_pkg::CC_TYPE, 5'd1, 7'd0, 7'd127);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd104, mccrl_pkg::CC_TYPE, 5'd1, 7'd127, 7'd0);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd105, mccrl_pkg::CC_TYPE, 5'd2, 7'd7, 7'd64);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'd105, mccrl_pkg::CC_TYPE, 5'd1, 7'd91, 7'd42);
    send_item(mccrl_tb_pkg::OP_TICK, 32'hFFFF_FFFF, 8'hFF, 5'd31, 7'd127, 7'd127);
    send_item(mccrl_tb_pkg::OP_MESSAGE, 32'h0000_0003, mccrl_pkg::CC_TYPE, 5'd3, 7'd11,
              7'd9);
    send_item(mccrl_tb_pkg::OP_TICK, 32'h0000_0030, 8'd0, 5'd0, 7'd0, 7'd0);
    ms_counter = 32'h0000_0030;

    run_phase(16'd0, 3, 1'b1, 1'b0);
    run_phase(16'hFFFF, 6000, 1'b0, 1'b0);
    run_phase(16'd40, 15, 1'b0, 1'b1);
    run_phase(16'd7, 4, 1'b0, 1'b0);
    run_phase(16'd300, 60, 1'b0, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
